FILE: hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared types, character constants, UTF-8 and hex helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd3;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [5:0] {
        ST_IDLE          = 6'b000001,
        ST_STR           = 6'b000010,
        ST_ESC           = 6'b000100,
        ST_HEX           = 6'b001000,
        ST_AFTER_HIGH    = 6'b010000,
        ST_AFTER_HIGH_BS = 6'b100000
    } pstate_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
    } res_t;

    // One request's results: an optional flushed high surrogate, then up to
    // four further results.
    typedef struct packed {
        logic            flush;
        logic [2:0][7:0] hi_bytes;
        logic [2:0]      main_n;
        res_t [3:0]      main;
    } job_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } utf8_t;

    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t u;
        u = '0;
        if (cp < 21'h00080) begin
            u.n    = 3'd1;
            u.b[0] = {1'b0, cp[6:0]};
        end
        else if (cp < 21'h00800) begin
            u.n    = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            u.n    = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end
        else begin
            u.n    = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
// Decodes a quoted JSON string, one byte per request, into output bytes.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry data_byte and end_of_text. Output
// channel: out_valid/out_ready carry out_byte, kind, error_code and last.
// A request causes up to six results, the final one marked by last; a
// request inside a string that only changes the parser state causes none.
// An accepted request's results are registered in the queue before the
// first is offered. The parser takes one request per cycle while the queue
// has room; the output side sends one result per cycle while out_ready is
// high. A two-entry queue of result groups sits between the parser and the
// output, and in_ready falls only when it is full, so a stalled receiver
// stops the input after two groups are waiting.
// After reset the parser awaits an opening quote and the queue is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_top
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [2:0]      error_code,
    output logic            last
);

    job_t front_job;
    job_t head_job;
    logic front_valid;
    logic queue_ready;
    logic head_valid;
    logic pop;

    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .job_valid   (front_valid),
        .job_ready   (queue_ready),
        .job         (front_job)
    );

    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (queue_ready),
        .push_job   (front_job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind),
        .error_code (error_code),
        .last       (last)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescaper front end
// Parses one request per cycle while the queue has room; queues its results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_text,
    output logic            job_valid,
    input  wire logic       job_ready,
    output job_t            job
);

    pstate_t     mode_reg, mode_next;
    logic [11:0] hex_reg, hex_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  held_reg, held_next;
    logic        held_flag_reg, held_flag_next;

    logic        accept;
    logic [4:0]  nib;
    logic [15:0] hex_full;
    logic        is_high;
    logic        is_low;
    utf8_t       enc_single;
    utf8_t       enc_pair;
    logic        do_body;
    logic        do_esc;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic        idle_step;

    assign in_ready   = job_ready;
    assign accept     = in_valid && in_ready;
    assign nib        = hex_nibble(data_byte);
    assign hex_full   = {hex_reg, nib[3:0]};
    assign is_high    = (hex_full[15:10] == 6'b110110);
    assign is_low     = (hex_full[15:10] == 6'b110111);
    assign enc_single = utf8_enc({5'b0, hex_full});
    assign enc_pair   = utf8_enc(21'h10000 + {1'b0, held_reg, hex_full[9:0]});

    always_comb
    begin
        mode_next      = mode_reg;
        hex_next       = hex_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        held_flag_next = held_flag_reg;
        job            = '0;
        job.hi_bytes[0] = 8'hED;
        job.hi_bytes[1] = {4'hA, held_reg[9:6]};
        job.hi_bytes[2] = {2'b10, held_reg[5:0]};
        do_body        = 1'b0;
        do_esc         = 1'b0;
        do_fail        = 1'b0;
        fail_code      = ERR_NO_QUOTE;
        idle_step      = 1'b0;

        unique case (mode_reg)
            ST_IDLE:
            begin
                idle_step = 1'b1;
            end
            ST_STR:
            begin
                if (end_of_text)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_UNTERMINATED;
                end
                else
                begin
                    do_body = 1'b1;
                end
            end
            ST_ESC:
            begin
                if (end_of_text)
                begin
                    job.flush = held_flag_reg;
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end
                else
                begin
                    do_esc = 1'b1;
                end
            end
            ST_HEX:
            begin
                if (end_of_text || !nib[4])
                begin
                    job.flush = held_flag_reg;
                    do_fail   = 1'b1;
                    fail_code = end_of_text ? ERR_TRUNCATED : ERR_BAD_HEX;
                end
                else if (cnt_reg != 2'd3)
                begin
                    hex_next = hex_full[11:0];
                    cnt_next = cnt_reg + 2'd1;
                end
                else
                begin
                    hex_next = '0;
                    cnt_next = '0;
                    if (held_flag_reg && is_low)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            job.main[i] = '{data: enc_pair.b[i], kind: KIND_BYTE,
                                            code: ERR_NO_QUOTE};
                        end
                        job.main_n     = enc_pair.n;
                        held_next      = '0;
                        held_flag_next = 1'b0;
                        mode_next      = ST_STR;
                    end
                    else
                    begin
                        job.flush = held_flag_reg;
                        if (is_high)
                        begin
                            held_next      = hex_full[9:0];
                            held_flag_next = 1'b1;
                            mode_next      = ST_AFTER_HIGH;
                        end
                        else
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                job.main[i] = '{data: enc_single.b[i], kind: KIND_BYTE,
                                                code: ERR_NO_QUOTE};
                            end
                            job.main_n     = enc_single.n;
                            held_next      = '0;
                            held_flag_next = 1'b0;
                            mode_next      = ST_STR;
                        end
                    end
                end
            end
            ST_AFTER_HIGH:
            begin
                if (end_of_text)
                begin
                    job.flush = held_flag_reg;
                    do_fail   = 1'b1;
                    fail_code = ERR_UNTERMINATED;
                end
                else if (data_byte == CH_BSLASH)
                begin
                    mode_next = ST_AFTER_HIGH_BS;
                end
                else
                begin
                    job.flush      = held_flag_reg;
                    held_next      = '0;
                    held_flag_next = 1'b0;
                    do_body        = 1'b1;
                end
            end
            ST_AFTER_HIGH_BS:
            begin
                if (end_of_text)
                begin
                    job.flush = held_flag_reg;
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end
                else if (data_byte == CH_U)
                begin
                    mode_next = ST_HEX;
                    hex_next  = '0;
                    cnt_next  = '0;
                end
                else
                begin
                    job.flush      = held_flag_reg;
                    held_next      = '0;
                    held_flag_next = 1'b0;
                    do_esc         = 1'b1;
                end
            end
            default:
            begin
                idle_step = 1'b1;
            end
        endcase

        if (idle_step)
        begin
            if (end_of_text || data_byte != CH_QUOTE)
            begin
                do_fail   = 1'b1;
                fail_code = ERR_NO_QUOTE;
            end
            else
            begin
                mode_next = ST_STR;
            end
        end

        if (do_body)
        begin
            if (data_byte == CH_QUOTE)
            begin
                job.main[0] = '{data: 8'h00, kind: KIND_CLOSE, code: ERR_NO_QUOTE};
                job.main_n  = 3'd1;
                mode_next      = ST_IDLE;
                hex_next       = '0;
                cnt_next       = '0;
                held_next      = '0;
                held_flag_next = 1'b0;
            end
            else if (data_byte == CH_BSLASH)
            begin
                mode_next = ST_ESC;
            end
            else
            begin
                job.main[0] = '{data: data_byte, kind: KIND_BYTE, code: ERR_NO_QUOTE};
                job.main_n  = 3'd1;
                mode_next   = ST_STR;
            end
        end

        if (do_esc)
        begin
            mode_next   = ST_STR;
            job.main_n  = 3'd1;
            job.main[0] = '{data: data_byte, kind: KIND_BYTE, code: ERR_NO_QUOTE};
            unique case (data_byte) inside
                CH_QUOTE, CH_BSLASH, CH_SLASH:
                begin
                    job.main[0].data = data_byte;
                end
                CH_B:
                begin
                    job.main[0].data = 8'h08;
                end
                CH_F:
                begin
                    job.main[0].data = 8'h0C;
                end
                CH_N:
                begin
                    job.main[0].data = 8'h0A;
                end
                CH_R:
                begin
                    job.main[0].data = 8'h0D;
                end
                CH_T:
                begin
                    job.main[0].data = 8'h09;
                end
                CH_U:
                begin
                    job.main_n = 3'd0;
                    mode_next  = ST_HEX;
                    hex_next   = '0;
                    cnt_next   = '0;
                end
                default:
                begin
                    job.main_n = 3'd0;
                    do_fail    = 1'b1;
                    fail_code  = ERR_BAD_ESCAPE;
                end
            endcase
        end

        if (do_fail)
        begin
            job.main[0]    = '{data: 8'h00, kind: KIND_ERROR, code: fail_code};
            job.main_n     = 3'd1;
            mode_next      = ST_IDLE;
            hex_next       = '0;
            cnt_next       = '0;
            held_next      = '0;
            held_flag_next = 1'b0;
        end
    end

    assign job_valid = accept && (job.flush || (job.main_n != 3'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_IDLE;
            hex_reg       <= '0;
            cnt_reg       <= '0;
            held_reg      <= '0;
            held_flag_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            hex_reg       <= hex_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            held_flag_reg <= held_flag_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescaper result queue
// Short first-in first-out queue of result groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  job_t      push_job,
    output logic      head_valid,
    input  wire logic pop,
    output job_t      head_job
);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescaper back end
// Delivers the head group's results, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  job_t            head_job,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic [2:0]      error_code,
    output logic            last
);

    logic [2:0] idx_reg, idx_next;
    logic [2:0] pre_n;
    logic [2:0] total;
    logic [2:0] main_idx;
    logic       accept;

    assign pre_n    = head_job.flush ? 3'd3 : 3'd0;
    assign total    = pre_n + head_job.main_n;
    assign main_idx = idx_reg - pre_n;
    assign out_valid = head_valid;
    assign last      = (idx_reg == total - 3'd1);
    assign accept    = out_valid && out_ready;
    assign pop       = accept && last;

    always_comb
    begin
        if (idx_reg < pre_n)
        begin
            out_byte   = head_job.hi_bytes[idx_reg[1:0]];
            kind       = KIND_BYTE;
            error_code = ERR_NO_QUOTE;
        end
        else
        begin
            out_byte   = head_job.main[main_idx[1:0]].data;
            kind       = head_job.main[main_idx[1:0]].kind;
            error_code = head_job.main[main_idx[1:0]].code;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (accept)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The result counter rests at zero whenever nothing is queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == 3'd0)
        else $error("result counter not at zero while queue empty");

    // The counter never walks past the results of the group at the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < total)
        else $error("result counter beyond group size");

    // A close or an error always ends the results of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CLOSE || kind == KIND_ERROR) |-> last)
        else $error("close or error not marked last");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the JSON string unescaper with UTF-8 output
// Sends quoted JSON strings, mostly well-formed with random content and some
// cut short or corrupted, one byte per request with random gaps on both
// channels. A scoreboard decodes every accepted request on its own and
// compares each output result, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import jsu_pkg::*;

    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [7:0][7:0] ESC_LETTERS =
        {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    typedef struct {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
        logic       last;
    } out_item_t;

    typedef struct {
        logic [7:0] b;
        logic       eot;
    } text_item_t;

    class utf8_scoreboard;
        pstate_t     mode;
        logic [15:0] hex_acc;
        int unsigned hex_count;
        logic [9:0]  high_bits;
        bit          high_valid;
        out_item_t   step_out[$];
        out_item_t   expected_out[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            go_idle();
            errors  = 0;
            checked = 0;
        endfunction

        function void go_idle();
            mode       = ST_IDLE;
            hex_acc    = '0;
            hex_count  = 0;
            high_bits  = '0;
            high_valid = 1'b0;
        endfunction

        function void add_out(logic [7:0] b, logic [1:0] k, logic [2:0] c);
            out_item_t r;
            r.data = b;
            r.kind = k;
            r.code = c;
            r.last = 1'b0;
            step_out = {step_out, r};
        endfunction

        function void raise_error(logic [2:0] c);
            add_out(8'h00, KIND_ERROR, c);
            go_idle();
        endfunction

        function void encode_cp(logic [20:0] cp);
            if (cp < 21'h80)
            begin
                add_out({1'b0, cp[6:0]}, KIND_BYTE, CODE_NONE);
            end
            else if (cp < 21'h800)
            begin
                add_out({3'b110, cp[10:6]}, KIND_BYTE, CODE_NONE);
                add_out({2'b10, cp[5:0]}, KIND_BYTE, CODE_NONE);
            end
            else if (cp < 21'h10000)
            begin
                add_out({4'b1110, cp[15:12]}, KIND_BYTE, CODE_NONE);
                add_out({2'b10, cp[11:6]}, KIND_BYTE, CODE_NONE);
                add_out({2'b10, cp[5:0]}, KIND_BYTE, CODE_NONE);
            end
            else
            begin
                add_out({5'b11110, cp[20:18]}, KIND_BYTE, CODE_NONE);
                add_out({2'b10, cp[17:12]}, KIND_BYTE, CODE_NONE);
                add_out({2'b10, cp[11:6]}, KIND_BYTE, CODE_NONE);
                add_out({2'b10, cp[5:0]}, KIND_BYTE, CODE_NONE);
            end
        endfunction

        function void flush_high();
            if (high_valid)
                encode_cp({5'd0, 6'b110110, high_bits});
            high_valid = 1'b0;
            high_bits  = '0;
        endfunction

        function void body_char(logic [7:0] b);
            if (b == CH_QUOTE)
            begin
                add_out(8'h00, KIND_CLOSE, CODE_NONE);
                go_idle();
            end
            else if (b == CH_BSLASH)
            begin
                mode = ST_ESC;
            end
            else
            begin
                add_out(b, KIND_BYTE, CODE_NONE);
                mode = ST_STR;
            end
        endfunction

        function void esc_char(logic [7:0] b);
            logic [7:0] v;
            mode = ST_STR;
            case (b)
                CH_QUOTE:  v = CH_QUOTE;
                CH_BSLASH: v = CH_BSLASH;
                CH_SLASH:  v = CH_SLASH;
                CH_B:      v = 8'h08;
                CH_F:      v = 8'h0C;
                CH_N:      v = 8'h0A;
                CH_R:      v = 8'h0D;
                CH_T:      v = 8'h09;
                CH_U:
                begin
                    mode      = ST_HEX;
                    hex_acc   = '0;
                    hex_count = 0;
                    return;
                end
                default:
                begin
                    raise_error(ERR_BAD_ESCAPE);
                    return;
                end
            endcase
            add_out(v, KIND_BYTE, CODE_NONE);
        endfunction

        function void single_code(logic [15:0] cp);
            if (cp >= 16'hD800 && cp <= 16'hDBFF)
            begin
                high_bits  = cp[9:0];
                high_valid = 1'b1;
                mode       = ST_AFTER_HIGH;
            end
            else
            begin
                encode_cp({5'd0, cp});
                mode = ST_STR;
            end
        endfunction

        function void hex_complete();
            logic [15:0] cp;
            logic [20:0] pair;
            cp        = hex_acc;
            hex_acc   = '0;
            hex_count = 0;
            if (high_valid)
            begin
                if (cp >= 16'hDC00 && cp <= 16'hDFFF)
                begin
                    pair = 21'h10000 + {1'b0, high_bits, cp[9:0]};
                    encode_cp(pair);
                    high_valid = 1'b0;
                    high_bits  = '0;
                    mode       = ST_STR;
                    return;
                end
                flush_high();
            end
            single_code(cp);
        endfunction

        function int nibble_of(logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39)
                return b - 8'h30;
            if (b >= 8'h61 && b <= 8'h66)
                return b - 8'h57;
            if (b >= 8'h41 && b <= 8'h46)
                return b - 8'h37;
            return -1;
        endfunction

        function void note_request(logic [7:0] b, logic eot);
            int nib;
            step_out.delete();
            case (mode)
                ST_STR:
                begin
                    if (eot)
                        raise_error(ERR_UNTERMINATED);
                    else
                        body_char(b);
                end
                ST_ESC:
                begin
                    if (eot)
                    begin
                        flush_high();
                        raise_error(ERR_TRUNCATED);
                    end
                    else
                    begin
                        esc_char(b);
                    end
                end
                ST_HEX:
                begin
                    nib = nibble_of(b);
                    if (eot)
                    begin
                        flush_high();
                        raise_error(ERR_TRUNCATED);
                    end
                    else if (nib < 0)
                    begin
                        flush_high();
                        raise_error(ERR_BAD_HEX);
                    end
                    else
                    begin
                        hex_acc = {hex_acc[11:0], nib[3:0]};
                        hex_count++;
                        if (hex_count >= 4)
                            hex_complete();
                    end
                end
                ST_AFTER_HIGH:
                begin
                    if (eot)
                    begin
                        flush_high();
                        raise_error(ERR_UNTERMINATED);
                    end
                    else if (b == CH_BSLASH)
                    begin
                        mode = ST_AFTER_HIGH_BS;
                    end
                    else
                    begin
                        flush_high();
                        body_char(b);
                    end
                end
                ST_AFTER_HIGH_BS:
                begin
                    if (eot)
                    begin
                        flush_high();
                        raise_error(ERR_TRUNCATED);
                    end
                    else if (b == CH_U)
                    begin
                        mode      = ST_HEX;
                        hex_acc   = '0;
                        hex_count = 0;
                    end
                    else
                    begin
                        flush_high();
                        esc_char(b);
                    end
                end
                default:
                begin
                    go_idle();
                    if (eot || b != CH_QUOTE)
                        raise_error(ERR_NO_QUOTE);
                    else
                        mode = ST_STR;
                end
            endcase
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                expected_out = {expected_out, step_out[i]};
        endfunction

        task report(string what);
            if (errors < 100)
                $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [7:0] b, logic [1:0] k, logic [2:0] c, logic l);
            out_item_t e;
            if (expected_out.size() == 0)
            begin
                report($sformatf("unexpected result byte %02h kind %0d code %0d last %0d",
                                 b, k, c, l));
                return;
            end
            e = expected_out.pop_front();
            if (b !== e.data || k !== e.kind || c !== e.code || l !== e.last)
                report($sformatf({"result %0d: got byte %02h kind %0d code %0d last %0d, ",
                                  "wanted byte %02h kind %0d code %0d last %0d"},
                                 checked, b, k, c, l, e.data, e.kind, e.code, e.last));
            checked++;
        endtask

        task close_out();
            if (expected_out.size() != 0)
                report($sformatf("%0d expected results never arrived", expected_out.size()));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;

    utf8_scoreboard sb = new();
    bit             steady = 1'b0;
    int unsigned    sent_count = 0;
    text_item_t     text_q[$];

    json_string_unescape_utf8_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .kind        (kind),
        .error_code  (error_code),
        .last        (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void add_byte(logic [7:0] b);
        text_item_t t;
        t.b   = b;
        t.eot = 1'b0;
        text_q = {text_q, t};
    endfunction

    function automatic void add_end();
        text_item_t t;
        t.b   = 8'($urandom_range(0, 255));
        t.eot = 1'b1;
        text_q = {text_q, t};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic void add_u(logic [15:0] v);
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        add_byte(hex_char(v[15:12]));
        add_byte(hex_char(v[11:8]));
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [15:0] pick_high();
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic logic [15:0] pick_low();
        return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 16'h7F));
            1:       return 16'($urandom_range(16'h80, 16'h7FF));
            2:       return 16'($urandom_range(0, 16'hFFFF));
            3:       return pick_high();
            default: return pick_low();
        endcase
    endfunction

    function automatic void add_escape();
        add_byte(CH_BSLASH);
        add_byte(ESC_LETTERS[$urandom_range(0, 7)]);
    endfunction

    function automatic void add_segment();
        case ($urandom_range(0, 10))
            0, 1: add_byte(body_byte());
            2:    add_escape();
            3:    add_u(pick_code());
            4, 5:
            begin
                add_u(pick_high());
                add_u(pick_low());
            end
            6:
            begin
                add_u(pick_high());
                add_u(pick_code());
            end
            7:
            begin
                add_u(pick_high());
                add_escape();
            end
            8:    add_u(pick_low());
            9:
            begin
                add_u(pick_high());
                add_byte(body_byte());
            end
            default:
            begin
                add_byte(CH_BSLASH);
                add_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void build_string();
        int unsigned cut;
        text_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 3) == 0)
                    add_end();
                else
                    add_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6))
            add_segment();
        if ($urandom_range(0, 9) == 0)
            add_end();
        else
            add_byte(CH_QUOTE);
        if ($urandom_range(0, 9) == 0)
            text_q[$urandom_range(1, text_q.size() - 1)].b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, text_q.size() - 1);
            while (text_q.size() > cut)
                void'(text_q.pop_back());
            add_end();
        end
    endfunction

    task automatic send_request(input logic [7:0] b, input logic eot);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_request(b, eot);
        sent_count++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_request(text_q[i].b, text_q[i].eot);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_out.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        text_q.delete();
        add_byte(8'h78);
        add_end();
        add_byte(CH_QUOTE);
        add_u(16'hD83D);
        add_u(16'hDE00);
        add_byte(CH_QUOTE);
        add_byte(CH_QUOTE);
        add_u(16'hDBFF);
        add_byte(8'hFF);
        add_end();
        add_byte(CH_QUOTE);
        add_byte(8'h00);
        add_byte(CH_BSLASH);
        add_byte(8'h71);
        send_text();
        wait_for_drain();

        while (sent_count < 430)
        begin
            steady = ($urandom_range(0, 4) == 0);
            build_string();
            send_text();
            if ($urandom_range(0, 19) == 0)
                wait_for_drain();
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (20) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int stall;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            sb.check_result(out_byte, kind, error_code, last);
        end
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
